// File: src/amg2_pkg.sv
// amg2_pkg: shared types and constants of the 2x2 gradient character block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package amg2_pkg;

    localparam int PIX_W = 8;
    localparam int CFG_W = 11;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LEVELS = 2'd2;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;
    localparam logic [7:0]       LEVELS_RST = 8'd4;
    localparam logic [CFG_W-1:0] HEIGHT_CAP = 11'd1024;

    // character codes
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_E     = 8'h45;

    // window queue between front and back
    localparam int QAW    = 2;
    localparam int QDEPTH = 1 << QAW;

    typedef struct packed {
        logic [PIX_W-1:0] p1;   // upper left
        logic [PIX_W-1:0] p2;   // upper
        logic [PIX_W-1:0] p3;   // left
        logic [PIX_W-1:0] p4;   // current
        logic             row_end;
        logic             frame_end;
    } window_t;

endpackage

// File: src/amg2_front.sv
// amg2_front: pixel intake, raster position, line store and window assembly.
// Depends on amg2_pkg.
`timescale 1ns / 1ps

module amg2_front
    import amg2_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [PIX_W-1:0] pixel,
    input  logic [CFG_W-1:0] image_width,
    input  logic [CFG_W-1:0] image_height,
    input  logic             q_full,
    output logic             q_push,
    output window_t          q_data
);

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam logic [WW-1:0] WMAX = WW'(MAX_WIDTH);

    logic [PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [PIX_W-1:0] upper_reg;

    logic [CW-1:0]    col_reg, col_next;
    logic [9:0]       row_reg, row_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_win_reg;
    logic             s1_row_end_reg;
    logic             s1_frame_end_reg;
    logic [PIX_W-1:0] s1_p4_reg;
    logic [PIX_W-1:0] left_reg;
    logic [PIX_W-1:0] upl_reg;

    logic [WW-1:0]    w_sat;
    logic [CFG_W-1:0] h_sat;
    logic [WW-1:0]    col_inc;
    logic [CFG_W-1:0] row_inc;
    logic             last_col, last_row;
    logic             accept, s1_adv;

    always_comb
    begin
        if (WW'(image_width) < WW'(2))
            w_sat = WW'(2);
        else if (WW'(image_width) > WMAX)
            w_sat = WMAX;
        else
            w_sat = WW'(image_width);

        if (image_height < CFG_W'(2))
            h_sat = CFG_W'(2);
        else if (image_height > HEIGHT_CAP)
            h_sat = HEIGHT_CAP;
        else
            h_sat = image_height;
    end

    assign col_inc  = WW'(col_reg) + WW'(1);
    assign row_inc  = CFG_W'(row_reg) + CFG_W'(1);
    assign last_col = (col_inc >= w_sat);
    assign last_row = (row_inc >= h_sat);

    // a stalled stage holds its line-store read data, since reads happen only on transfer
    assign s1_adv = s1_valid_reg && (!s1_win_reg || !q_full);
    assign full   = s1_valid_reg && !s1_adv;
    assign accept = push && !full;

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        s1_valid_next = s1_valid_reg;
        if (s1_adv)
            s1_valid_next = 1'b0;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? 10'd0 : row_inc[9:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            left_reg     <= '0;
            upl_reg      <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            if (s1_adv)
            begin
                left_reg <= s1_p4_reg;
                upl_reg  <= upper_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_p4_reg        <= pixel;
            s1_win_reg       <= (col_reg != '0) && (row_reg != 10'd0);
            s1_row_end_reg   <= last_col;
            s1_frame_end_reg <= last_col && last_row;
        end
    end

    // read-before-write: the upper pixel comes out as the current one goes in
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upper_reg         <= line_mem[col_reg];
            line_mem[col_reg] <= pixel;
        end
    end

    assign q_push = s1_adv && s1_win_reg;

    always_comb
    begin
        q_data.p1        = upl_reg;
        q_data.p2        = upper_reg;
        q_data.p3        = left_reg;
        q_data.p4        = s1_p4_reg;
        q_data.row_end   = s1_row_end_reg;
        q_data.frame_end = s1_frame_end_reg;
    end

endmodule

// File: src/amg2_fifo.sv
// amg2_fifo: short flop-based queue of windows between front and back.
// Depends on amg2_pkg.
`timescale 1ns / 1ps

module amg2_fifo
    import amg2_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  window_t wr_data,
    output logic    q_full,
    input  logic    rd_en,
    output window_t rd_data,
    output logic    q_empty
);

    window_t        slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;
    logic           do_wr, do_rd;

    assign q_full  = (count_reg == (QAW+1)'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + (QAW+1)'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - (QAW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: src/amg2_back.sv
// amg2_back: gradient maximum over a window, then character lookup and result register.
// Depends on amg2_pkg.
`timescale 1ns / 1ps

module amg2_back
    import amg2_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  window_t    q_data,
    input  logic       q_empty,
    output logic       q_pop,
    input  logic [7:0] grey_levels,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] char_code,
    output logic [7:0] gradient,
    output logic       row_end,
    output logic       frame_end
);

    logic       a_valid_reg, a_valid_next;
    logic [7:0] a_grad_reg;
    logic       a_row_end_reg, a_frame_end_reg;
    logic       o_valid_reg, o_valid_next;
    logic [7:0] o_char_reg, o_grad_reg;
    logic       o_row_end_reg, o_frame_end_reg;

    logic               o_ready, a_adv, a_take;
    logic signed [9:0]  s_h, s_v, m_h, m_v;
    logic [7:0]         gh, gv, gp, gn, g01, g23, g_max;

    function automatic logic [7:0] map_char(input logic [7:0] g, input logic [7:0] levels);
        logic [7:0] c;
        c = CH_N;
        unique case (levels)
            8'd2:
            begin
                if (g == 8'd0)      c = CH_HASH;
                else if (g == 8'd1) c = CH_SPACE;
            end
            8'd3:
            begin
                if (g == 8'd0)      c = CH_HASH;
                else if (g == 8'd1) c = CH_DOT;
                else if (g == 8'd2) c = CH_SPACE;
            end
            8'd4:
            begin
                if (g == 8'd0)      c = CH_SPACE;
                else if (g == 8'd1) c = CH_DOT;
                else if (g == 8'd2) c = CH_COLON;
                else if (g == 8'd3) c = CH_HASH;
            end
            default: c = CH_E;
        endcase
        return c;
    endfunction

    // half-difference toward zero equals magnitude shifted right by one
    always_comb
    begin
        s_h = $signed({2'b00, q_data.p1}) - $signed({2'b00, q_data.p2})
            + $signed({2'b00, q_data.p3}) - $signed({2'b00, q_data.p4});
        s_v = $signed({2'b00, q_data.p1}) + $signed({2'b00, q_data.p2})
            - $signed({2'b00, q_data.p3}) - $signed({2'b00, q_data.p4});
        m_h = (s_h < 0) ? -s_h : s_h;
        m_v = (s_v < 0) ? -s_v : s_v;
        gh  = m_h[8:1];
        gv  = m_v[8:1];
        gp  = (q_data.p1 > q_data.p4) ? q_data.p1 - q_data.p4 : q_data.p4 - q_data.p1;
        gn  = (q_data.p2 > q_data.p3) ? q_data.p2 - q_data.p3 : q_data.p3 - q_data.p2;
        g01 = (gv > gh) ? gv : gh;
        g23 = (gn > gp) ? gn : gp;
        g_max = (g23 > g01) ? g23 : g01;
    end

    assign o_ready = !o_valid_reg || pop;
    assign a_adv   = a_valid_reg && o_ready;
    assign a_take  = !a_valid_reg || a_adv;
    assign q_pop   = a_take && !q_empty;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_take)
            a_valid_next = !q_empty;
        o_valid_next = o_valid_reg;
        if (o_ready)
            o_valid_next = a_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_grad_reg      <= g_max;
            a_row_end_reg   <= q_data.row_end;
            a_frame_end_reg <= q_data.frame_end;
        end
        if (a_adv)
        begin
            o_char_reg      <= map_char(a_grad_reg, grey_levels);
            o_grad_reg      <= a_grad_reg;
            o_row_end_reg   <= a_row_end_reg;
            o_frame_end_reg <= a_frame_end_reg;
        end
    end

    assign empty     = !o_valid_reg;
    assign char_code = o_char_reg;
    assign gradient  = o_grad_reg;
    assign row_end   = o_row_end_reg;
    assign frame_end = o_frame_end_reg;

endmodule

// File: src/ascii_max_gradient_2x2_top.sv
// ascii_max_gradient_2x2_top: top level with configuration registers and assertions.
// Depends on amg2_pkg, amg2_front, amg2_fifo and amg2_back.
`timescale 1ns / 1ps

// Usage
//   Pixels enter in raster order on the push/full queue port; a transfer takes
//   place when push is high and full is low. Every pixel at column and row of
//   at least one closes a 2x2 window and yields one result: the largest of its
//   four gradients, its character and the row/frame end marks. Pixels of the
//   first row or column yield nothing but fill the line store.
//   Results leave on the empty/pop queue port, oldest first.
//   A result passes the front stage, queue, gradient stage and output register.
//   Throughput: one pixel per cycle while full is low, as the single line-store
//   port reads the upper pixel and writes the current one in the same cycle.
//   When pop stays low, the output register, the gradient stage and a
//   four-window queue fill in turn and full then rises; nothing is dropped.
//   Configuration: cfg_valid/cfg_ready (ready always high), cfg_index 0 width,
//   1 height, 2 grey levels; write only while the block is idle.
//   Reset: positions return to the frame origin, registers to 640, 480 and 4.
//   The line store is not cleared; the first row never reads it for output.

module ascii_max_gradient_2x2_top
    import amg2_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [PIX_W-1:0] pixel,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       char_code,
    output logic [7:0]       gradient,
    output logic             row_end,
    output logic             frame_end,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic [7:0]       levels_reg, levels_next;

    window_t push_data, head_data;
    logic    q_push, q_full, q_pop, q_empty;
    logic    cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        levels_next = levels_reg;
        if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_next  = cfg_data;
                CFG_HEIGHT: height_next = cfg_data;
                CFG_LEVELS: levels_next = cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            levels_reg <= LEVELS_RST;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            levels_reg <= levels_next;
        end
    end

    amg2_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel        (pixel),
        .image_width  (width_reg),
        .image_height (height_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (push_data)
    );

    amg2_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (push_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (head_data),
        .q_empty (q_empty)
    );

    amg2_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (head_data),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .grey_levels (levels_reg),
        .pop         (pop),
        .empty       (empty),
        .char_code   (char_code),
        .gradient    (gradient),
        .row_end     (row_end),
        .frame_end   (frame_end)
    );

    // front must never offer a window the queue cannot take
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("window queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("window queue underflow");

    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_end) |-> row_end)
        else $error("frame end without row end");

    a_level_map: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (levels_reg == 8'd2 || levels_reg == 8'd3 || levels_reg == 8'd4)
            && $stable(levels_reg)) |-> (char_code != CH_E))
        else $error("supported grey level mapped as unsupported");

endmodule

// File: test/tb_ascii_max_gradient_2x2_top.sv
// tb_ascii_max_gradient_2x2_top: self-checking bench for the 2x2 gradient character block.
// Depends on amg2_pkg and ascii_max_gradient_2x2_top; predicts every window and
// checks the result stream under random push/pop idling.
`timescale 1ns / 1ps

module tb_ascii_max_gradient_2x2_top;
    import amg2_pkg::*;

    localparam int MAX_W      = 1024;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 8;

    typedef struct packed {
        logic [7:0] char_code;
        logic [7:0] gradient;
        logic       row_end;
        logic       frame_end;
    } glyph_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             push      = 1'b0;
    logic [PIX_W-1:0] pixel     = '0;
    logic             pop       = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [1:0]       cfg_index = CFG_WIDTH;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             full;
    logic             empty;
    logic             cfg_ready;
    logic [7:0]       char_code;
    logic [7:0]       gradient;
    logic             row_end;
    logic             frame_end;

    logic [PIX_W-1:0] pixel_q [$];
    glyph_t           expected_glyphs [$];
    int               sender_gap_pct = 0;
    int               recv_gap_pct   = 0;
    int               errors         = 0;
    int               cycles         = 0;

    // predictor state and register copies
    logic [PIX_W-1:0] line_mem [MAX_W];
    bit               line_seen [MAX_W];
    logic [PIX_W-1:0] left_px   = '0;
    logic [PIX_W-1:0] corner_px = '0;
    int               col_pos   = 0;
    int               row_pos   = 0;
    logic [CFG_W-1:0] width_reg  = WIDTH_RST;
    logic [CFG_W-1:0] height_reg = HEIGHT_RST;
    logic [7:0]       levels_reg = LEVELS_RST;

    ascii_max_gradient_2x2_top #(
        .MAX_WIDTH (MAX_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .empty     (empty),
        .pop       (pop),
        .char_code (char_code),
        .gradient  (gradient),
        .row_end   (row_end),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int clamp(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int eff_width();
        return clamp(int'(width_reg), 2, MAX_W);
    endfunction

    function automatic logic [7:0] glyph_for(input int g, input logic [7:0] levels);
        case (levels)
            8'd2:
                case (g)
                    0:       return CH_HASH;
                    1:       return CH_SPACE;
                    default: return CH_N;
                endcase
            8'd3:
                case (g)
                    0:       return CH_HASH;
                    1:       return CH_DOT;
                    2:       return CH_SPACE;
                    default: return CH_N;
                endcase
            8'd4:
                case (g)
                    0:       return CH_SPACE;
                    1:       return CH_DOT;
                    2:       return CH_COLON;
                    3:       return CH_HASH;
                    default: return CH_N;
                endcase
            default: return CH_E;
        endcase
    endfunction

    // true when growing to new_w cannot make a window read an unwritten line entry
    function automatic bit line_covers(input int new_w);
        if (row_pos == 0)
            return 1'b1;
        for (int i = 0; i < new_w; i++)
            if (!line_seen[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic predict_window(input logic [PIX_W-1:0] px);
        int     w, h, a, b, d, e, s, g, gv, gp, gn;
        bit     last_col;
        glyph_t res;
        w = eff_width();
        h = clamp(int'(height_reg), 2, int'(HEIGHT_CAP));
        a = int'(corner_px);
        b = int'(line_mem[col_pos]);
        d = int'(left_px);
        e = int'(px);
        last_col = (col_pos + 1 >= w);
        if (col_pos >= 1 && row_pos >= 1)
        begin
            s  = a - b + d - e;
            g  = (s < 0 ? -s : s) / 2;
            s  = a - d + b - e;
            gv = (s < 0 ? -s : s) / 2;
            gp = (a > e) ? a - e : e - a;
            gn = (b > d) ? b - d : d - b;
            if (gv > g)
                g = gv;
            if (gp > g)
                g = gp;
            if (gn > g)
                g = gn;
            res.char_code = glyph_for(g, levels_reg);
            res.gradient  = 8'(g);
            res.row_end   = last_col;
            res.frame_end = last_col && (row_pos + 1 >= h);
            expected_glyphs.push_back(res);
        end
        corner_px          = line_mem[col_pos];
        line_mem[col_pos]  = px;
        line_seen[col_pos] = 1'b1;
        left_px            = px;
        if (last_col)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
    endtask

    // pixel driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                predict_window(pixel);
            if (!push || !full)
            begin
                if (pixel_q.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct)
                begin
                    push  <= 1'b1;
                    pixel <= pixel_q.pop_front();
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        glyph_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_glyphs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result char %h grad %0d row_end %b frame_end %b",
                             $time, char_code, gradient, row_end, frame_end);
                end
                else
                begin
                    want = expected_glyphs.pop_front();
                    if (char_code !== want.char_code || gradient !== want.gradient ||
                        row_end !== want.row_end || frame_end !== want.frame_end)
                    begin
                        errors++;
                        $display("%0t: expected char %h grad %0d row_end %b frame_end %b",
                                 $time, want.char_code, want.gradient, want.row_end,
                                 want.frame_end);
                        $display("%0t:      got char %h grad %0d row_end %b frame_end %b",
                                 $time, char_code, gradient, row_end, frame_end);
                    end
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb_ascii_max_gradient_2x2_top: errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:  width_reg  = val;
            CFG_HEIGHT: height_reg = val;
            CFG_LEVELS: levels_reg = val[7:0];
            default:    ;
        endcase
    endtask

    task automatic wait_drained();
        while (pixel_q.size() != 0 || push || expected_glyphs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic queue_packed(input logic [95:0] bytes, input int count);
        @(negedge clk);
        for (int i = 0; i < count; i++)
            pixel_q.push_back(bytes[8*(count-1-i) +: 8]);
        wait_drained();
    endtask

    // squeeze the frame down to two rows and finish the current one
    task automatic return_to_origin();
        int n;
        if (row_pos != 0)
        begin
            write_reg(CFG_HEIGHT, 11'd2);
            n = (col_pos < eff_width()) ? eff_width() - col_pos : 1;
            @(negedge clk);
            repeat (n) pixel_q.push_back(8'($urandom_range(0, 255)));
            wait_drained();
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val,
                             input logic [CFG_W-1:0] lv_val, input int count);
        int         style;
        logic [7:0] base;
        if (clamp(int'(w_val), 2, MAX_W) > eff_width() &&
            !line_covers(clamp(int'(w_val), 2, MAX_W)))
            return_to_origin();
        write_reg(CFG_WIDTH, w_val);
        write_reg(CFG_HEIGHT, h_val);
        write_reg(CFG_LEVELS, lv_val);
        style = $urandom_range(0, 2);
        base  = 8'($urandom_range(0, 252));
        @(negedge clk);
        repeat (count)
        begin
            case (style)
                0:       pixel_q.push_back(8'($urandom_range(0, 255)));
                1:       pixel_q.push_back(base + 8'($urandom_range(0, 3)));
                default: pixel_q.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
            endcase
        end
        wait_drained();
    endtask

    initial
    begin
        logic [CFG_W-1:0] w_val, h_val, lv_val;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        sender_gap_pct = 20;
        recv_gap_pct   = 59;

        // directed: saturated 2x2 frames at reset grey levels
        write_reg(CFG_WIDTH, 11'd1);
        write_reg(CFG_HEIGHT, 11'd0);
        queue_packed(64'h00000001_00000200, 8);
        // 3x3 frame, two levels, full-scale swings
        write_reg(CFG_LEVELS, 11'd2);
        write_reg(CFG_WIDTH, 11'd3);
        write_reg(CFG_HEIGHT, 11'd3);
        queue_packed(72'h00_01_00_01_00_01_FF_00_FF, 9);
        // three levels, then an unsupported level with upper data bits set
        write_reg(CFG_LEVELS, 11'd3);
        write_reg(CFG_WIDTH, 11'd2);
        write_reg(CFG_HEIGHT, 11'd2);
        queue_packed(32'h02000001, 4);
        write_reg(CFG_LEVELS, 11'h700);
        queue_packed(32'hFF0000FF, 4);

        for (int p = 0; p < 12; p++)
        begin
            if (p == 4)
            begin
                sender_gap_pct = 59;
                recv_gap_pct   = 20;
            end
            else if (p == 8)
            begin
                sender_gap_pct = 0;
                recv_gap_pct   = 0;
            end
            if (p == 6)
            begin
                run_phase(11'h7FF, 11'd2, 11'd4, 40);
            end
            else if (p == 10)
            begin
                run_phase(11'd2, 11'h7FF, 11'd3, 40);
            end
            else
            begin
                w_val  = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2047))
                                                     : CFG_W'($urandom_range(0, 9));
                h_val  = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2047))
                                                     : CFG_W'($urandom_range(0, 6));
                lv_val = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 2047))
                                                     : CFG_W'($urandom_range(2, 4));
                run_phase(w_val, h_val, lv_val, $urandom_range(30, 55));
            end
        end

        wait_drained();
        if (errors == 0 && expected_glyphs.size() == 0)
            $display("tb_ascii_max_gradient_2x2_top: clean");
        else
            $display("tb_ascii_max_gradient_2x2_top: errors");
        $finish;
    end

endmodule
